/* rtl/core/prb_pkg.sv */
// ----------------------------------------------------------------------------
// prb_pkg
// Shared types, constants and helpers for the primitive run batcher.
// ----------------------------------------------------------------------------
`default_nettype none

package prb_pkg;

    localparam int MAX_RUN_VERTS = 256;
    localparam int LANES         = 4;
    localparam int LANE_BITS     = 2;
    localparam int ROW_DEPTH     = MAX_RUN_VERTS / LANES;
    localparam int ROW_BITS      = 6;
    localparam int LEN_BITS      = 9;
    localparam int BUD_BITS      = 12;
    localparam int PRIM_BITS     = 10;
    localparam int VERT_BITS     = 16;
    localparam int OFF_BITS      = 10;

    localparam logic [PRIM_BITS-1:0] PRIM_LIMIT   = 10'd1023;
    localparam logic [1:0]           TRI_CORNERS  = 2'd3;
    localparam logic [BUD_BITS-1:0]  BUDGET_FLOOR = 12'h800;
    localparam logic [LEN_BITS-1:0]  LIST_FULL    = LEN_BITS'(MAX_RUN_VERTS);

    localparam logic [1:0] REG_CORNERS = 2'd0;
    localparam logic [1:0] REG_BUDGET  = 2'd1;
    localparam logic [1:0] REG_COST    = 2'd2;
    localparam logic [1:0] REG_RESERVE = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CORNER,
        S_READ,
        S_CMP,
        S_MISS,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [VERT_BITS-1:0] corner_a;
        logic [VERT_BITS-1:0] corner_b;
        logic [VERT_BITS-1:0] corner_c;
        logic                 last_prim;
    } in_item_t;

    typedef struct packed {
        logic                  kind;
        logic [OFF_BITS-1:0]   offset_a;
        logic [OFF_BITS-1:0]   offset_b;
        logic [OFF_BITS-1:0]   offset_c;
        logic [1:0]            new_count;
        logic [VERT_BITS-1:0]  new_vert_a;
        logic [VERT_BITS-1:0]  new_vert_b;
        logic [VERT_BITS-1:0]  new_vert_c;
        logic                  run_end;
        logic [LEN_BITS-1:0]   run_vertex_count;
        logic [PRIM_BITS-1:0]  run_prim_count;
    } out_item_t;

    typedef struct packed {
        logic                 any;
        logic [LANE_BITS-1:0] lane;
    } hit_t;

    function automatic logic [BUD_BITS-1:0] sat_sub(input logic [BUD_BITS-1:0] b,
                                                    input logic [3:0] x);
        logic signed [BUD_BITS:0] diff;
        begin
            diff = $signed({b[BUD_BITS-1], b}) - $signed({9'd0, x});
            if (diff < $signed({1'b1, BUDGET_FLOOR}))
            begin
                sat_sub = BUDGET_FLOOR;
            end
            else
            begin
                sat_sub = diff[BUD_BITS-1:0];
            end
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/core/prb_ram.sv */
// ----------------------------------------------------------------------------
// prb_ram
// Generic single write port RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module prb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/prb_lane.sv */
// ----------------------------------------------------------------------------
// prb_lane
// One search lane: a bank of the run vertex list and its comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module prb_lane (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [prb_pkg::ROW_BITS-1:0]  waddr,
    input  wire logic [prb_pkg::VERT_BITS-1:0] wdata,
    input  wire logic [prb_pkg::ROW_BITS-1:0]  raddr,
    input  wire logic [prb_pkg::VERT_BITS-1:0] key,
    input  wire logic                          live,
    output logic                               hit
);

    logic [prb_pkg::VERT_BITS-1:0] rdata;

    prb_ram #(
        .WIDTH(prb_pkg::VERT_BITS),
        .DEPTH(prb_pkg::ROW_DEPTH)
    ) u_bank (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign hit = live && (rdata == key);

endmodule

`default_nettype wire

/* rtl/core/prb_merge.sv */
// ----------------------------------------------------------------------------
// prb_merge
// Picks the lowest lane that matched, which is the earliest list position.
// ----------------------------------------------------------------------------
`default_nettype none

module prb_merge (
    input  wire logic [prb_pkg::LANES-1:0] hits,
    output prb_pkg::hit_t                  found
);

    always_comb
    begin
        found = '0;
        for (int l = prb_pkg::LANES - 1; l >= 0; l--)
        begin
            if (hits[l])
            begin
                found.any  = 1'b1;
                found.lane = l[prb_pkg::LANE_BITS-1:0];
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/primitive_run_batcher.sv */
// ----------------------------------------------------------------------------
// primitive_run_batcher
// Packs primitives into vertex runs under a quadword budget.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Each item yields one
// or two results, each shown for one cycle with result_valid high; a run
// that must close before the primitive gives an extra result first.
// The receiver cannot stall, so results are simply presented and dropped.
// Each corner is looked up in the current run list, which is split over four
// lanes that each compare one entry per row; a row is read from the RAM in
// S_READ and compared in S_CMP. A corner enters S_CORNER, then visits these
// states row by row to a hit or the end of the run, then S_MISS on a miss.
// The item then commits in S_DONE; its result is shown once the block is
// back in idle, so a new item is taken only after the last has committed; a
// run that must close first repeats the corner search. The user must write
// the configuration registers through the APB port only while idle; the
// block does not enforce this. Reset clears the run state and loads the
// register defaults; the vertex list itself needs no clearing since only
// entries below the length are read.
// ----------------------------------------------------------------------------
`default_nettype none

module primitive_run_batcher (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire prb_pkg::in_item_t item,
    output logic                   result_valid,
    output prb_pkg::out_item_t     result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    prb_pkg::state_t state_reg, state_next;

    logic [1:0]                     cfg_corners_reg;
    logic [9:0]                     cfg_budget_reg;
    logic [3:0]                     cfg_cost_reg;
    logic [9:0]                     cfg_reserve_reg;

    logic [prb_pkg::VERT_BITS-1:0]  corner_reg [3];
    logic [prb_pkg::VERT_BITS-1:0]  corner_next [3];
    logic                           last_reg, last_next;
    logic [1:0]                     k_reg, k_next;
    logic [prb_pkg::ROW_BITS-1:0]   row_reg, row_next;
    logic [prb_pkg::LEN_BITS-1:0]   tlen_reg, tlen_next;
    logic [prb_pkg::BUD_BITS-1:0]   tbud_reg, tbud_next;
    logic                           waive_reg, waive_next;
    logic [prb_pkg::OFF_BITS-1:0]   off_reg [3];
    logic [prb_pkg::OFF_BITS-1:0]   off_next [3];
    logic [prb_pkg::VERT_BITS-1:0]  nv_reg [3];
    logic [prb_pkg::VERT_BITS-1:0]  nv_next [3];
    logic [1:0]                     added_reg, added_next;
    logic [prb_pkg::LEN_BITS-1:0]   len_reg, len_next;
    logic [prb_pkg::BUD_BITS-1:0]   bud_reg, bud_next;
    logic [prb_pkg::PRIM_BITS-1:0]  prims_reg, prims_next;
    logic                           result_valid_reg, result_valid_next;
    prb_pkg::out_item_t             result_reg, result_next;

    logic [prb_pkg::VERT_BITS-1:0]  key;
    logic [prb_pkg::LANES-1:0]      lane_live;
    logic [prb_pkg::LANES-1:0]      lane_hit;
    logic [prb_pkg::LANES-1:0]      lane_we;
    logic                           append;
    prb_pkg::hit_t                  found;
    logic [1:0]                     n_last;
    logic                           row_end;
    logic                           refuse;
    logic [prb_pkg::BUD_BITS-1:0]   bud_commit;
    logic [prb_pkg::PRIM_BITS-1:0]  prims_commit;
    logic                           cfg_write;

    assign key       = corner_reg[k_reg];
    assign n_last    = (cfg_corners_reg == prb_pkg::TRI_CORNERS) ? 2'd2 : 2'd1;
    assign row_end   = {({1'b0, row_reg} + 7'd1), 2'b00} >= tlen_reg;
    assign refuse    = (tlen_reg >= prb_pkg::LIST_FULL)
                       || (!waive_reg
                           && ($signed({tbud_reg[prb_pkg::BUD_BITS-1], tbud_reg})
                               < $signed({3'd0, cfg_reserve_reg})));
    assign append    = (state_reg == prb_pkg::S_MISS) && !refuse;
    assign bud_commit   = prb_pkg::sat_sub(tbud_reg, 4'd1);
    assign prims_commit = prims_reg + 10'd1;

    always_comb
    begin
        for (int l = 0; l < prb_pkg::LANES; l++)
        begin
            lane_live[l] = {1'b0, row_reg, l[prb_pkg::LANE_BITS-1:0]} < tlen_reg;
            lane_we[l]   = append && (tlen_reg[prb_pkg::LANE_BITS-1:0]
                                      == l[prb_pkg::LANE_BITS-1:0]);
        end
    end

    genvar g;
    generate
        for (g = 0; g < prb_pkg::LANES; g++)
        begin : g_lane
            prb_lane u_lane (
                .clk  (clk),
                .we   (lane_we[g]),
                .waddr(tlen_reg[prb_pkg::LANE_BITS +: prb_pkg::ROW_BITS]),
                .wdata(key),
                .raddr(row_reg),
                .key  (key),
                .live (lane_live[g]),
                .hit  (lane_hit[g])
            );
        end
    endgenerate

    prb_merge u_merge (
        .hits (lane_hit),
        .found(found)
    );

    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        prdata = '0;
        case (paddr[3:2])
            prb_pkg::REG_CORNERS: prdata = {30'd0, cfg_corners_reg};
            prb_pkg::REG_BUDGET:  prdata = {22'd0, cfg_budget_reg};
            prb_pkg::REG_COST:    prdata = {28'd0, cfg_cost_reg};
            prb_pkg::REG_RESERVE: prdata = {22'd0, cfg_reserve_reg};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_corners_reg <= 2'd3;
            cfg_budget_reg  <= 10'd315;
            cfg_cost_reg    <= 4'd4;
            cfg_reserve_reg <= 10'd5;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                prb_pkg::REG_CORNERS: cfg_corners_reg <= pwdata[1:0];
                prb_pkg::REG_BUDGET:  cfg_budget_reg  <= pwdata[9:0];
                prb_pkg::REG_COST:    cfg_cost_reg    <= pwdata[3:0];
                prb_pkg::REG_RESERVE: cfg_reserve_reg <= pwdata[9:0];
                default:              cfg_corners_reg <= cfg_corners_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= prb_pkg::S_IDLE;
            len_reg          <= '0;
            bud_reg          <= 12'd315;
            prims_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            len_reg          <= len_next;
            bud_reg          <= bud_next;
            prims_reg        <= prims_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            corner_reg[i] <= corner_next[i];
            off_reg[i]    <= off_next[i];
            nv_reg[i]     <= nv_next[i];
        end
        last_reg   <= last_next;
        k_reg      <= k_next;
        row_reg    <= row_next;
        tlen_reg   <= tlen_next;
        tbud_reg   <= tbud_next;
        waive_reg  <= waive_next;
        added_reg  <= added_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        for (int i = 0; i < 3; i++)
        begin
            corner_next[i] = corner_reg[i];
            off_next[i]    = off_reg[i];
            nv_next[i]     = nv_reg[i];
        end
        last_next         = last_reg;
        k_next            = k_reg;
        row_next          = row_reg;
        tlen_next         = tlen_reg;
        tbud_next         = tbud_reg;
        waive_next        = waive_reg;
        added_next        = added_reg;
        len_next          = len_reg;
        bud_next          = bud_reg;
        prims_next        = prims_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;

        case (state_reg)
            prb_pkg::S_IDLE:
            begin
                if (start)
                begin
                    corner_next[0] = item.corner_a;
                    corner_next[1] = item.corner_b;
                    corner_next[2] = item.corner_c;
                    last_next      = item.last_prim;
                    k_next         = 2'd0;
                    added_next     = 2'd0;
                    for (int i = 0; i < 3; i++)
                    begin
                        off_next[i] = '0;
                        nv_next[i]  = '0;
                    end
                    waive_next = (prims_reg == '0);
                    if (prims_reg == '0)
                    begin
                        len_next  = '0;
                        bud_next  = {2'd0, cfg_budget_reg};
                        tlen_next = '0;
                        tbud_next = {2'd0, cfg_budget_reg};
                    end
                    else
                    begin
                        tlen_next = len_reg;
                        tbud_next = bud_reg;
                    end
                    state_next = prb_pkg::S_CORNER;
                end
            end

            prb_pkg::S_CORNER:
            begin
                row_next = '0;
                if (tlen_reg == '0)
                begin
                    state_next = prb_pkg::S_MISS;
                end
                else
                begin
                    state_next = prb_pkg::S_READ;
                end
            end

            prb_pkg::S_READ:
            begin
                state_next = prb_pkg::S_CMP;
            end

            prb_pkg::S_CMP:
            begin
                if (found.any)
                begin
                    off_next[k_reg] = {row_reg, found.lane, 2'b00};
                    if (k_reg == n_last)
                    begin
                        state_next = prb_pkg::S_DONE;
                    end
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = prb_pkg::S_CORNER;
                    end
                end
                else if (row_end)
                begin
                    state_next = prb_pkg::S_MISS;
                end
                else
                begin
                    row_next   = row_reg + 6'd1;
                    state_next = prb_pkg::S_READ;
                end
            end

            prb_pkg::S_MISS:
            begin
                if (refuse)
                begin
                    result_valid_next            = 1'b1;
                    result_next                  = '0;
                    result_next.kind             = 1'b1;
                    result_next.run_end          = 1'b1;
                    result_next.run_vertex_count = len_reg;
                    result_next.run_prim_count   = prims_reg;
                    len_next   = '0;
                    prims_next = '0;
                    bud_next   = {2'd0, cfg_budget_reg};
                    tlen_next  = '0;
                    tbud_next  = {2'd0, cfg_budget_reg};
                    waive_next = 1'b1;
                    k_next     = 2'd0;
                    added_next = 2'd0;
                    for (int i = 0; i < 3; i++)
                    begin
                        off_next[i] = '0;
                        nv_next[i]  = '0;
                    end
                    state_next = prb_pkg::S_CORNER;
                end
                else
                begin
                    off_next[k_reg]    = {tlen_reg[7:0], 2'b00};
                    nv_next[added_reg] = key;
                    added_next         = added_reg + 2'd1;
                    tlen_next          = tlen_reg + 9'd1;
                    tbud_next          = prb_pkg::sat_sub(tbud_reg, cfg_cost_reg);
                    if (k_reg == n_last)
                    begin
                        state_next = prb_pkg::S_DONE;
                    end
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = prb_pkg::S_CORNER;
                    end
                end
            end

            prb_pkg::S_DONE:
            begin
                result_valid_next       = 1'b1;
                result_next             = '0;
                result_next.offset_a    = off_reg[0];
                result_next.offset_b    = off_reg[1];
                result_next.offset_c    = off_reg[2];
                result_next.new_count   = added_reg;
                result_next.new_vert_a  = nv_reg[0];
                result_next.new_vert_b  = nv_reg[1];
                result_next.new_vert_c  = nv_reg[2];
                if ((bud_commit == '0) || last_reg || (prims_commit >= prb_pkg::PRIM_LIMIT))
                begin
                    result_next.run_end          = 1'b1;
                    result_next.run_vertex_count = tlen_reg;
                    result_next.run_prim_count   = prims_commit;
                    len_next   = '0;
                    prims_next = '0;
                    bud_next   = {2'd0, cfg_budget_reg};
                end
                else
                begin
                    len_next   = tlen_reg;
                    prims_next = prims_commit;
                    bud_next   = bud_commit;
                end
                state_next = prb_pkg::S_IDLE;
            end

            default:
            begin
                state_next = prb_pkg::S_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != prb_pkg::S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

/* bench/prb_checker.sv */
// ----------------------------------------------------------------------------
// prb_checker
// Watches the item, result and register channels of the primitive run
// batcher, predicts every result from its own copy of the run state and
// compares each result in order with its prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module prb_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  prb_pkg::in_item_t   item,
    input  logic                result_valid,
    input  prb_pkg::out_item_t  result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output int                  fail_count,
    output int                  pending,
    output int                  results_seen,
    output int                  runs_closed
);

    prb_pkg::out_item_t expected_mem [8];
    int          exp_head;
    int          exp_tail;
    logic [1:0]  corners_reg;
    logic [9:0]  budget_reg;
    logic [3:0]  cost_reg;
    logic [9:0]  reserve_reg;
    logic [15:0] vert_list [prb_pkg::MAX_RUN_VERTS];
    logic [15:0] corner_v [3];
    int          run_len;
    int          budget_left;
    int          prims_in_run;

    assign pending = exp_tail - exp_head;

    function automatic int floor_sub(input int b, input int x);
        int r;
        r = b - x;
        return (r < -2048) ? -2048 : r;
    endfunction

    task automatic queue_expected(input prb_pkg::out_item_t r);
        expected_mem[exp_tail[2:0]] = r;
        exp_tail = exp_tail + 1;
    endtask

    task automatic place_prim(input int n, input bit waive, output bit ok,
                              output prb_pkg::out_item_t r);
        int len;
        int bud;
        int added;
        int pos;
        r = '0;
        ok = 1'b0;
        len = run_len;
        bud = budget_left;
        added = 0;
        for (int k = 0; k < n; k++)
        begin
            pos = len;
            for (int i = 0; i < len; i++)
            begin
                if (vert_list[i] == corner_v[k])
                begin
                    pos = i;
                    break;
                end
            end
            if (pos == len)
            begin
                if (len >= prb_pkg::MAX_RUN_VERTS)
                    return;
                if (!waive && bud < int'(reserve_reg))
                    return;
                vert_list[len] = corner_v[k];
                len++;
                bud = floor_sub(bud, int'(cost_reg));
                case (added)
                    0: r.new_vert_a = corner_v[k];
                    1: r.new_vert_b = corner_v[k];
                    default: r.new_vert_c = corner_v[k];
                endcase
                added++;
            end
            case (k)
                0: r.offset_a = 10'(pos * 4);
                1: r.offset_b = 10'(pos * 4);
                default: r.offset_c = 10'(pos * 4);
            endcase
        end
        r.new_count = added[1:0];
        run_len = len;
        budget_left = floor_sub(bud, 1);
        prims_in_run++;
        ok = 1'b1;
    endtask

    task automatic close_run(inout prb_pkg::out_item_t r);
        r.run_end = 1'b1;
        r.run_vertex_count = run_len[8:0];
        r.run_prim_count = prims_in_run[9:0];
        run_len = 0;
        prims_in_run = 0;
        budget_left = int'(budget_reg);
    endtask

    task automatic predict_prim(input prb_pkg::in_item_t it);
        int                 n;
        bit                 ok;
        prb_pkg::out_item_t r;
        prb_pkg::out_item_t closed;
        n = (corners_reg == prb_pkg::TRI_CORNERS) ? 3 : 2;
        corner_v[0] = it.corner_a;
        corner_v[1] = it.corner_b;
        corner_v[2] = it.corner_c;
        if (prims_in_run == 0)
        begin
            run_len = 0;
            budget_left = int'(budget_reg);
        end
        place_prim(n, prims_in_run == 0, ok, r);
        if (!ok)
        begin
            closed = '0;
            closed.kind = 1'b1;
            close_run(closed);
            queue_expected(closed);
            place_prim(n, 1'b1, ok, r);
        end
        if (budget_left == 0 || it.last_prim
            || prims_in_run >= int'(prb_pkg::PRIM_LIMIT))
            close_run(r);
        queue_expected(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corners_reg = prb_pkg::TRI_CORNERS;
            budget_reg = 10'd315;
            cost_reg = 4'd4;
            reserve_reg = 10'd5;
            run_len = 0;
            prims_in_run = 0;
            budget_left = 315;
            fail_count = 0;
            results_seen = 0;
            runs_closed = 0;
            exp_head = 0;
            exp_tail = 0;
        end
        else
        begin
            if (result_valid)
            begin
                results_seen = results_seen + 1;
                if (result.run_end)
                    runs_closed = runs_closed + 1;
                if (exp_tail == exp_head)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result %p", $realtime, result);
                end
                else
                begin
                    if (result !== expected_mem[exp_head[2:0]])
                    begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10)
                            $display("%0t: mismatch\n  expected %p\n  actual   %p",
                                     $realtime, expected_mem[exp_head[2:0]], result);
                    end
                    exp_head = exp_head + 1;
                end
            end
            if (start && !busy)
                predict_prim(item);
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    prb_pkg::REG_CORNERS: corners_reg = pwdata[1:0];
                    prb_pkg::REG_BUDGET:  budget_reg = pwdata[9:0];
                    prb_pkg::REG_COST:    cost_reg = pwdata[3:0];
                    prb_pkg::REG_RESERVE: reserve_reg = pwdata[9:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives primitives into the run batcher through several register settings:
// default runs, long two-corner and three-corner runs, tiny budgets,
// a budget driven negative until the primitive count limit closes the run,
// and random settings. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    localparam int STALL_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    prb_pkg::in_item_t  item;
    logic               result_valid;
    prb_pkg::out_item_t result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;
    int                 results_seen;
    int                 runs_closed;
    int                 prims_sent;
    int                 stall_cycles;
    int                 idle_pct;

    primitive_run_batcher DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .result_valid(result_valid), .result(result), .psel(psel),
        .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    prb_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .result_valid(result_valid), .result(result), .psel(psel),
        .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr),
        .pwdata(pwdata), .fail_count(fail_count), .pending(pending),
        .results_seen(results_seen), .runs_closed(runs_closed)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(input int corners, input int budget, input int cost,
                              input int reserve);
        wait_idle();
        write_reg(prb_pkg::REG_CORNERS, 32'(corners));
        write_reg(prb_pkg::REG_BUDGET, 32'(budget));
        write_reg(prb_pkg::REG_COST, 32'(cost));
        write_reg(prb_pkg::REG_RESERVE, 32'(reserve));
    endtask

    task automatic send_prim(input logic [15:0] a, input logic [15:0] b,
                             input logic [15:0] c, input logic last);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(99) < idle_pct)
            gap++;
        repeat (gap) @(negedge clk);
        while (busy)
            @(negedge clk);
        item <= '{corner_a: a, corner_b: b, corner_c: c, last_prim: last};
        start <= 1'b1;
        @(negedge clk);
        start <= 1'b0;
        prims_sent++;
        if (prims_sent < 470)
            idle_pct = 38;
        else if (prims_sent < 940)
            idle_pct = 84;
        else
            idle_pct = 0;
    endtask

    task automatic random_prims(input int count, input int pool, input int last_odds);
        logic [15:0] base;
        logic [15:0] v [3];
        base = 16'($urandom);
        for (int i = 0; i < count; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if ($urandom_range(15) == 0)
                    v[k] = 16'($urandom);
                else
                    v[k] = base + 16'($urandom_range(pool - 1));
            end
            send_prim(v[0], v[1], v[2], $urandom_range(last_odds - 1) == 0);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        prims_sent = 0;
        idle_pct = 38;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_prim(16'h0000, 16'hffff, 16'h0000, 1'b0);
        send_prim(16'hffff, 16'hffff, 16'hffff, 1'b0);
        send_prim(16'h0000, 16'h0001, 16'h0002, 1'b0);
        send_prim(16'h0002, 16'h0001, 16'h0000, 1'b1);
        send_prim(16'h5555, 16'haaaa, 16'h5555, 1'b1);
        send_prim(16'h1234, 16'h1234, 16'h4321, 1'b0);
        random_prims(8, 40, 10);

        set_config(2, 1, 15, 1023);
        send_prim(16'h0001, 16'h0002, 16'hffff, 1'b0);
        send_prim(16'h0003, 16'h0001, 16'h0000, 1'b0);
        send_prim(16'h0001, 16'h0001, 16'h0000, 1'b1);
        set_config(3, 1023, 1, 0);
        send_prim(16'h0010, 16'h0011, 16'h0012, 1'b0);
        send_prim(16'h0012, 16'h0011, 16'h0010, 1'b1);

        set_config(2, 1023, 1, 0);
        random_prims(60, 700, 400);
        set_config(0, 1, 15, 1023);
        random_prims(60, 8, 20);
        set_config(3, 1023, 1, 0);
        random_prims(60, 900, 400);

        set_config(3, 20, 15, 0);
        for (int i = 0; i < 1030; i++)
        begin
            case ($urandom_range(2))
                0: send_prim(16'h00a0, 16'h00a1, 16'h00a2, 1'b0);
                1: send_prim(16'h00a2, 16'h00a0, 16'h00a1, 1'b0);
                default: send_prim(16'h00a1, 16'h00a2, 16'h00a0, 1'b0);
            endcase
        end

        for (int p = 0; p < 4; p++)
        begin
            set_config($urandom_range(3), $urandom_range(1023, 1), $urandom_range(15, 1),
                       $urandom_range(60));
            random_prims(40, $urandom_range(200, 4), 30);
        end

        wait_idle();
        repeat (20) @(negedge clk);
        $display("Sent %0d primitives under several register settings.", prims_sent);
        $display("Checked %0d results, %0d of them closing a run.", results_seen,
                 runs_closed);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/prb_pkg.sv
rtl/core/prb_ram.sv
rtl/core/prb_lane.sv
rtl/core/prb_merge.sv
rtl/core/primitive_run_batcher.sv
bench/prb_checker.sv
bench/testbench.sv
